### hdl/spl_pkg.sv
// ----------------------------------------------------------------------------
// spl_pkg: shared types and constants of the sorted priority list
// Request and status codes, controller-to-datapath command and status structs.
// ----------------------------------------------------------------------------
package spl_pkg;

	localparam int CAPACITY_DEF  = 16;
	localparam int DATA_BITS_DEF = 32;
	localparam int PRIO_BITS_DEF = 32;
	localparam int REQ_BITS      = 4;
	localparam int STATUS_BITS   = 2;
	localparam int COUNT_BITS    = 5;

	typedef enum logic [REQ_BITS-1:0] {
		REQ_INSERT     = 4'd0,
		REQ_PEEK_TAIL  = 4'd1,
		REQ_PEEK_HEAD  = 4'd2,
		REQ_POP_TAIL   = 4'd3,
		REQ_POP_HEAD   = 4'd4,
		REQ_FIND_DATA  = 4'd5,
		REQ_FIND_BOTH  = 4'd6,
		REQ_DEL_DATA   = 4'd7,
		REQ_DEL_BOTH   = 4'd8
	} req_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// controller commands to the datapath
	typedef struct packed {
		logic load;      // capture the request
		logic insert;    // shift in at insertion point
		logic remove;    // remove at the selected slot
		logic sel_tail;  // select the tail, else head / match
		logic sel_match; // select the first match
		logic use_prio;  // match on priority as well
		logic capture;   // register the selected entry as the result
	} dp_cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic empty;
		logic full;
		logic found;
	} dp_stat_t;

endpackage

### hdl/spl_ctrl.sv
// ----------------------------------------------------------------------------
// spl_ctrl: request sequencer
// Takes a transaction, issues one datapath command, then presents the result.
// ----------------------------------------------------------------------------
module spl_ctrl import spl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [REQ_BITS-1:0]    req_type,
	output logic                   out_valid,
	input  logic                   out_stall,
	output dp_cmd_t                cmd,
	input  dp_stat_t               stat,
	output logic [STATUS_BITS-1:0] status,
	output logic                   entry_ok
);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_t;

	state_t            state_q;
	logic [REQ_BITS-1:0] req_q;
	logic [STATUS_BITS-1:0] status_q;
	logic              ok_q;
	logic              acc;
	logic              out_done;
	logic [STATUS_BITS-1:0] st_n;

	// accept when idle, or when the held result leaves this cycle
	assign out_done = (state_q == S_OUT) && !out_stall;
	assign in_stall = !((state_q == S_IDLE) || out_done);
	assign acc      = in_valid && !in_stall;
	assign out_valid = (state_q == S_OUT);
	assign status   = status_q;
	assign entry_ok = ok_q;

	// decode the held request into a status and datapath command
	always_comb begin
		cmd = '0;
		st_n = ST_NOT_FOUND;
		cmd.load = acc;
		if (state_q == S_EXEC) begin
			cmd.capture = 1'b1;
			unique case (req_q)
				REQ_INSERT: begin
					st_n = stat.full ? ST_FULL : ST_OK;
					cmd.insert = !stat.full;
				end
				REQ_PEEK_TAIL, REQ_PEEK_HEAD, REQ_POP_TAIL, REQ_POP_HEAD: begin
					st_n = stat.empty ? ST_EMPTY : ST_OK;
					cmd.sel_tail = (req_q == REQ_PEEK_TAIL) || (req_q == REQ_POP_TAIL);
					cmd.remove = !stat.empty &&
						((req_q == REQ_POP_TAIL) || (req_q == REQ_POP_HEAD));
				end
				REQ_FIND_DATA, REQ_FIND_BOTH, REQ_DEL_DATA, REQ_DEL_BOTH: begin
					cmd.sel_match = 1'b1;
					cmd.use_prio = (req_q == REQ_FIND_BOTH) || (req_q == REQ_DEL_BOTH);
					if (stat.empty)
						st_n = ((req_q == REQ_DEL_DATA) || (req_q == REQ_DEL_BOTH))
							? ST_EMPTY : ST_NOT_FOUND;
					else
						st_n = stat.found ? ST_OK : ST_NOT_FOUND;
					cmd.remove = stat.found &&
						((req_q == REQ_DEL_DATA) || (req_q == REQ_DEL_BOTH));
				end
				default: st_n = ST_NOT_FOUND;
			endcase
		end
	end

	// hold state and the registered result status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			req_q    <= '0;
			status_q <= ST_OK;
			ok_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (acc) begin
					state_q <= S_EXEC;
					req_q   <= req_type;
				end
				S_EXEC: begin
					state_q  <= S_OUT;
					status_q <= st_n;
					ok_q     <= (st_n == ST_OK);
				end
				S_OUT: if (acc) begin
					state_q <= S_EXEC;
					req_q   <= req_type;
				end else if (out_done) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hdl/spl_dp.sv
// ----------------------------------------------------------------------------
// spl_dp: sorted slot array datapath
// Shift register of entries with parallel compare for insert point and match.
// ----------------------------------------------------------------------------
module spl_dp import spl_pkg::*; #(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int DATA_BITS = DATA_BITS_DEF,
	parameter int PRIO_BITS = PRIO_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dp_cmd_t                     cmd,
	output dp_stat_t                    stat,
	input  logic signed [DATA_BITS-1:0] item_data,
	input  logic signed [PRIO_BITS-1:0] item_priority,
	input  logic                        entry_ok,
	output logic signed [DATA_BITS-1:0] entry_data,
	output logic signed [PRIO_BITS-1:0] entry_priority,
	output logic [COUNT_BITS-1:0]       entry_count
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [DATA_BITS-1:0] slot_d_q [CAPACITY];
	logic signed [PRIO_BITS-1:0] slot_p_q [CAPACITY];
	logic [CW-1:0]               fill_q;
	logic signed [DATA_BITS-1:0] d_q, od_q;
	logic signed [PRIO_BITS-1:0] p_q, op_q;
	logic [CAPACITY-1:0]         live, gt, hit, first_hit;
	logic [CAPACITY-1:0]         at_end, ins_at;
	logic [CAPACITY-1:0]         rm_mask, sel_mask;
	logic [IW-1:0]               tail_idx;
	logic signed [DATA_BITS-1:0] sel_d;
	logic signed [PRIO_BITS-1:0] sel_p;

	assign tail_idx   = IW'(fill_q - CW'(1));
	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == CW'(CAPACITY));
	assign stat.found = |hit;

	// compare every live slot against the held request
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			live[i]   = CW'(i) < fill_q;
			at_end[i] = CW'(i) == fill_q;
			gt[i]     = live[i] && (slot_p_q[i] > p_q);
			hit[i]    = live[i] && (slot_d_q[i] == d_q) &&
				(!cmd.use_prio || (slot_p_q[i] == p_q));
		end
	end

	// new entry lands on the first greater slot, or just past the tail
	assign ins_at = (gt | at_end) & ~{gt[CAPACITY-2:0], 1'b0};

	// isolate the first match and everything from it upwards
	assign first_hit = hit & (~hit + CAPACITY'(1));
	assign rm_mask   = ~(first_hit - CAPACITY'(1));

	// one-hot selection of the result slot
	always_comb begin
		if (cmd.sel_match)
			sel_mask = first_hit;
		else if (cmd.sel_tail)
			sel_mask = CAPACITY'(1) << tail_idx;
		else
			sel_mask = CAPACITY'(1);
		sel_d = '0;
		sel_p = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (sel_mask[i]) begin
				sel_d = sel_d | slot_d_q[i];
				sel_p = sel_p | slot_p_q[i];
			end
		end
	end

	// register the request and the result, and shift the array on insert and remove
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q <= item_data;
			p_q <= item_priority;
		end
		if (cmd.capture) begin
			if (cmd.insert) begin
				od_q <= d_q;
				op_q <= p_q;
			end else begin
				od_q <= sel_d;
				op_q <= sel_p;
			end
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (cmd.insert && gt[i] && (i + 1 < CAPACITY)) begin
				slot_d_q[(i + 1) % CAPACITY] <= slot_d_q[i];
				slot_p_q[(i + 1) % CAPACITY] <= slot_p_q[i];
			end
			if (cmd.insert && ins_at[i]) begin
				slot_d_q[i] <= d_q;
				slot_p_q[i] <= p_q;
			end
			if (cmd.remove && (cmd.sel_match ? rm_mask[i] : !cmd.sel_tail) &&
				i + 1 < CAPACITY) begin
				slot_d_q[i] <= slot_d_q[(i + 1) % CAPACITY];
				slot_p_q[i] <= slot_p_q[(i + 1) % CAPACITY];
			end
		end
	end

	// track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fill_q <= '0;
		else if (cmd.insert)
			fill_q <= fill_q + CW'(1);
		else if (cmd.remove)
			fill_q <= fill_q - CW'(1);
	end

	assign entry_data     = entry_ok ? od_q : '0;
	assign entry_priority = entry_ok ? op_q : '0;
	assign entry_count    = COUNT_BITS'(fill_q);

endmodule

### hdl/sorted_priority_list.sv
// ----------------------------------------------------------------------------
// sorted_priority_list: bounded double-ended priority queue
// Sorted slot array with insert, peek, pop, find and delete requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries req_type, item_data, item_priority.
//   Output channel out_valid/out_stall carries status, entry_data,
//   entry_priority and entry_count; every request gives one result.
//   An accepted request passes through the execute state to the output state,
//   where out_valid is high. One request is in work at a time; a new request
//   is accepted in the cycle the previous result is taken. Each request takes
//   a single compare and shift pass over all slots.
//   While out_stall is high the result holds and in_stall stays high.
//   Reset empties the list; slot contents are left as they were.
// ----------------------------------------------------------------------------
module sorted_priority_list import spl_pkg::*; #(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int DATA_BITS = DATA_BITS_DEF,
	parameter int PRIO_BITS = PRIO_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [REQ_BITS-1:0]           req_type,
	input  logic signed [DATA_BITS-1:0]   item_data,
	input  logic signed [PRIO_BITS-1:0]   item_priority,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [STATUS_BITS-1:0]        status,
	output logic signed [DATA_BITS-1:0]   entry_data,
	output logic signed [PRIO_BITS-1:0]   entry_priority,
	output logic [COUNT_BITS-1:0]         entry_count
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     entry_ok;

	spl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .stat(stat), .status(status), .entry_ok(entry_ok)
	);

	spl_dp #(.CAPACITY(CAPACITY), .DATA_BITS(DATA_BITS), .PRIO_BITS(PRIO_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.item_data(item_data), .item_priority(item_priority), .entry_ok(entry_ok),
		.entry_data(entry_data), .entry_priority(entry_priority),
		.entry_count(entry_count)
	);

endmodule

### hdl/spl_checker.sv
// ----------------------------------------------------------------------------
// spl_checker: port-level checks of the sorted priority list
// Observes the top-level ports over time.
// ----------------------------------------------------------------------------
module spl_checker import spl_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [STATUS_BITS-1:0] status,
	input logic [COUNT_BITS-1:0]  entry_count
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled result changed");

	// an accepted transaction gives a result once the execute state has passed
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("result missing");

	// the input is stalled while a result waits
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("accepted under output stall");

	// a full status comes with a nonzero count
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count != '0)
		else $error("full status with empty count");

endmodule

bind sorted_priority_list spl_checker u_spl_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.entry_count(entry_count)
);
